FILE: src/cce_pkg.sv
package cce_pkg;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_CODE   = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4,
    MODE_STRING = 3'd5,
    MODE_ESCAPE = 3'd6
  } mode_t;

  // Characters the scanner looks for
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;

  // Output field widths and limits
  localparam int REPORT_BITS = 24;
  localparam int COUNT_BITS  = 24;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Results one byte can cause, and the output queue that absorbs them
  localparam int MAX_RES  = 3;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = 2;
  localparam int Q_CNT_W  = 3;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  count;
    logic [REPORT_BITS-1:0] line;
    logic                   last;
    logic [7:0]             data;
  } result_t;

endpackage

FILE: src/cce_scanner.sv
module cce_scanner #(
  parameter int LINE_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_i,
  input  logic [7:0]                 byte_i,
  input  logic                       eot_i,
  output cce_pkg::result_t [2:0]     res_o,
  output logic [1:0]                 res_n_o
);

  localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  cce_pkg::mode_t                 mode_r, mode_nxt;
  logic [LINE_BITS-1:0]           line_r, line_nxt;
  logic [LINE_BITS-1:0]           start_r, start_nxt;
  logic [LINE_BITS-1:0]           nl_r, nl_nxt;
  logic [7:0]                     hb_r, hb_nxt;
  logic                           hv_r, hv_nxt;
  logic [cce_pkg::COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic                           c1_en, c2_en, fin_en, fin_is_line;
  logic [7:0]                     c1_b, c2_b;
  logic                           line_inc, nl_inc;
  logic [LINE_BITS:0]             blk_sum;
  logic [LINE_BITS-1:0]           blk_line, fin_line;
  cce_pkg::result_t [2:0]         res;
  logic [1:0]                     n;

  // Decode the byte into content/finish operations, then apply them in order
  always_comb begin
    mode_nxt    = mode_r;
    line_nxt    = line_r;
    start_nxt   = start_r;
    nl_nxt      = nl_r;
    hb_nxt      = hb_r;
    hv_nxt      = hv_r;
    cnt_nxt     = cnt_r;
    c1_en       = 1'b0;
    c1_b        = byte_i;
    c2_en       = 1'b0;
    c2_b        = byte_i;
    fin_en      = 1'b0;
    fin_is_line = 1'b0;
    line_inc    = 1'b0;
    nl_inc      = 1'b0;
    res         = '0;
    n           = 2'd0;

    case (mode_r)
      cce_pkg::MODE_SLASH: begin
        if (byte_i == cce_pkg::CH_SLASH) begin
          mode_nxt  = cce_pkg::MODE_LINE;
          start_nxt = line_r;
        end else if (byte_i == cce_pkg::CH_STAR) begin
          mode_nxt  = cce_pkg::MODE_BLOCK;
          start_nxt = line_r;
          nl_nxt    = '0;
        end else if (byte_i == cce_pkg::CH_QUOTE) begin
          mode_nxt = cce_pkg::MODE_STRING;
        end else begin
          mode_nxt = cce_pkg::MODE_CODE;
          line_inc = (byte_i == cce_pkg::CH_LF);
        end
      end
      cce_pkg::MODE_LINE: begin
        if (byte_i == cce_pkg::CH_LF) begin
          fin_en      = 1'b1;
          fin_is_line = 1'b1;
          line_inc    = 1'b1;
          mode_nxt    = cce_pkg::MODE_CODE;
        end else if (byte_i != cce_pkg::CH_CR) begin
          c1_en = 1'b1;
        end
      end
      cce_pkg::MODE_BLOCK: begin
        if (byte_i == cce_pkg::CH_STAR) begin
          mode_nxt = cce_pkg::MODE_STAR;
        end else begin
          line_inc = (byte_i == cce_pkg::CH_LF);
          nl_inc   = (byte_i == cce_pkg::CH_LF);
          c1_en    = (byte_i != cce_pkg::CH_CR);
        end
      end
      cce_pkg::MODE_STAR: begin
        if (byte_i == cce_pkg::CH_SLASH) begin
          fin_en   = 1'b1;
          mode_nxt = cce_pkg::MODE_CODE;
        end else if (byte_i == cce_pkg::CH_STAR) begin
          c1_en = 1'b1;
          c1_b  = cce_pkg::CH_STAR;
        end else begin
          // Lone star is content, then the byte itself as block text
          c1_en    = 1'b1;
          c1_b     = cce_pkg::CH_STAR;
          line_inc = (byte_i == cce_pkg::CH_LF);
          nl_inc   = (byte_i == cce_pkg::CH_LF);
          c2_en    = (byte_i != cce_pkg::CH_CR);
          mode_nxt = cce_pkg::MODE_BLOCK;
        end
      end
      cce_pkg::MODE_STRING: begin
        if (byte_i == cce_pkg::CH_BACKSLASH) begin
          mode_nxt = cce_pkg::MODE_ESCAPE;
        end else if (byte_i == cce_pkg::CH_QUOTE) begin
          mode_nxt = cce_pkg::MODE_CODE;
        end else begin
          line_inc = (byte_i == cce_pkg::CH_LF);
        end
      end
      cce_pkg::MODE_ESCAPE: begin
        line_inc = (byte_i == cce_pkg::CH_LF);
        mode_nxt = cce_pkg::MODE_STRING;
      end
      default: begin
        if (byte_i == cce_pkg::CH_SLASH) begin
          mode_nxt = cce_pkg::MODE_SLASH;
        end else if (byte_i == cce_pkg::CH_QUOTE) begin
          mode_nxt = cce_pkg::MODE_STRING;
        end else begin
          mode_nxt = cce_pkg::MODE_CODE;
          line_inc = (byte_i == cce_pkg::CH_LF);
        end
      end
    endcase

    // Saturating line and newline counters
    if (line_inc && line_r != LINE_MAX) begin
      line_nxt = line_r + LINE_ONE;
    end
    if (nl_inc && nl_nxt != LINE_MAX) begin
      nl_nxt = nl_nxt + LINE_ONE;
    end

    // Close an open comment at end of text; a pending star is content first
    if (eot_i) begin
      if (mode_nxt == cce_pkg::MODE_LINE) begin
        fin_en      = 1'b1;
        fin_is_line = 1'b1;
      end else if (mode_nxt == cce_pkg::MODE_BLOCK || mode_nxt == cce_pkg::MODE_STAR) begin
        if (mode_nxt == cce_pkg::MODE_STAR) begin
          if (c1_en) begin
            c2_en = 1'b1;
            c2_b  = cce_pkg::CH_STAR;
          end else begin
            c1_en = 1'b1;
            c1_b  = cce_pkg::CH_STAR;
          end
        end
        fin_en = 1'b1;
      end
    end

    // Block comment line: start + newlines - 1, floored at start, saturating
    blk_sum = {1'b0, start_nxt} + {1'b0, nl_nxt} - {{LINE_BITS{1'b0}}, 1'b1};
    if (nl_nxt == '0) begin
      blk_line = start_nxt;
    end else if (blk_sum[LINE_BITS]) begin
      blk_line = LINE_MAX;
    end else begin
      blk_line = blk_sum[LINE_BITS-1:0];
    end
    fin_line = fin_is_line ? start_nxt : blk_line;

    // Apply content operations: emit the held byte, hold the new one
    if (c1_en) begin
      if (hv_nxt) begin
        res[n].data = hb_nxt;
        n = n + 2'd1;
      end
      hb_nxt = c1_b;
      hv_nxt = 1'b1;
    end
    if (c2_en) begin
      if (hv_nxt) begin
        res[n].data = hb_nxt;
        n = n + 2'd1;
      end
      hb_nxt = c2_b;
      hv_nxt = 1'b1;
    end
    if (fin_en && hv_nxt) begin
      if (cnt_nxt != cce_pkg::COUNT_MAX) begin
        cnt_nxt = cnt_nxt + cce_pkg::COUNT_BITS'(1);
      end
      res[n].data  = hb_nxt;
      res[n].last  = 1'b1;
      res[n].line  = cce_pkg::REPORT_BITS'(fin_line);
      res[n].count = cnt_nxt;
      n = n + 2'd1;
      hv_nxt = 1'b0;
    end

    // Fresh text after the final byte
    if (eot_i) begin
      mode_nxt  = cce_pkg::MODE_CODE;
      line_nxt  = LINE_ONE;
      start_nxt = '0;
      nl_nxt    = '0;
      hb_nxt    = '0;
      hv_nxt    = 1'b0;
      cnt_nxt   = '0;
    end
  end

  assign res_o   = res;
  assign res_n_o = step_i ? n : 2'd0;

  // Advance scanner state on each consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= cce_pkg::MODE_CODE;
      line_r  <= LINE_ONE;
      start_r <= '0;
      nl_r    <= '0;
      hb_r    <= '0;
      hv_r    <= 1'b0;
      cnt_r   <= '0;
    end else if (step_i) begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      start_r <= start_nxt;
      nl_r    <= nl_nxt;
      hb_r    <= hb_nxt;
      hv_r    <= hv_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // A held byte exists only inside a comment
  a_held_in_comment: assert property (@(posedge clk) disable iff (!rst_n)
    hv_r |-> (mode_r == cce_pkg::MODE_LINE || mode_r == cce_pkg::MODE_BLOCK ||
              mode_r == cce_pkg::MODE_STAR))
    else $error("held byte outside a comment");

  // End of text returns the scanner to its reset state
  a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && eot_i) |=> (mode_r == cce_pkg::MODE_CODE && line_r == LINE_ONE &&
                           cnt_r == '0 && !hv_r))
    else $error("scanner not reset after end of text");

  // The line counter never drops below one
  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line counter reached zero");

endmodule

FILE: src/cce_out_queue.sv
module cce_out_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cce_pkg::result_t [2:0] push_i,
  input  logic [1:0]             push_n_i,
  output logic                   room_o,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output cce_pkg::result_t       head_o
);

  cce_pkg::result_t             mem_r [cce_pkg::Q_DEPTH];
  logic [cce_pkg::Q_PTR_W-1:0]  wr_r, rd_r;
  logic [cce_pkg::Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign head_o     = mem_r[rd_r];
  assign room_o     = (cnt_r <= cce_pkg::Q_CNT_W'(cce_pkg::Q_DEPTH - cce_pkg::MAX_RES));
  assign cnt_nxt    = cnt_r + cce_pkg::Q_CNT_W'(push_n_i) - cce_pkg::Q_CNT_W'(pop);

  // Store up to three words per cycle at consecutive slots
  always_ff @(posedge clk) begin
    for (int i = 0; i < cce_pkg::MAX_RES; i++) begin
      if (2'(i) < push_n_i) begin
        mem_r[wr_r + cce_pkg::Q_PTR_W'(i)] <= push_i[i];
      end
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + cce_pkg::Q_PTR_W'(push_n_i);
      rd_r  <= rd_r + cce_pkg::Q_PTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  // Fill count stays within the queue
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cce_pkg::Q_CNT_W'(cce_pkg::Q_DEPTH))
    else $error("output queue over capacity");

  // Pushes only land when there is room for them
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n_i != 2'd0) |-> (cnt_r + cce_pkg::Q_CNT_W'(push_n_i)
                            <= cce_pkg::Q_CNT_W'(cce_pkg::Q_DEPTH)))
    else $error("push into a full output queue");

  // Pointer distance matches the fill count
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_r - rd_r) == cnt_r[cce_pkg::Q_PTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

FILE: src/c_comment_extractor.sv
// Channel | Dir | Handshake          | Payload
// in_     | in  | tvalid/tready      | tdata[7:0] text byte, tlast end of text
// out_    | out | tvalid/tready      | tdata comment byte/line/count, tlast last byte
//
// A byte enters the input register when accepted and is scanned from there once
// the queue has room, pushing up to three words into a four-word queue, which
// registers them for out_. A byte is scanned only while the queue holds at most
// one word, so with out_tready high the rate is one byte per cycle and a byte
// yielding two or three words stalls the next bytes until the queue holds one word.
// Reset (rst_n low, synchronous) clears mode, line to one, count and queue.
module c_comment_extractor #(
  parameter int LINE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] comment_byte, [31:8] report_line,
                                  // [55:32] comment_count
  output logic        out_tlast   // last_of_comment
);

  logic                   in_valid_r;
  logic [7:0]             in_byte_r;
  logic                   in_eot_r;
  logic                   room, step;
  cce_pkg::result_t [2:0] res;
  logic [1:0]             res_n;
  cce_pkg::result_t       head;

  assign step      = in_valid_r && room;
  assign in_tready = !in_valid_r || step;

  // Input register: load a new word when empty or when the held one is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eot_r  <= in_tlast;
    end
  end

  cce_scanner #(
    .LINE_BITS(LINE_BITS)
  ) u_scanner (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .byte_i  (in_byte_r),
    .eot_i   (in_eot_r),
    .res_o   (res),
    .res_n_o (res_n)
  );

  cce_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (res),
    .push_n_i   (res_n),
    .room_o     (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head_o     (head)
  );

  assign out_tdata = {head.count, head.line, head.data};
  assign out_tlast = head.last;

endmodule

FILE: dv/c_comment_extractor_checker.sv
`timescale 1ns / 100ps
module c_comment_extractor_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // [7:0] comment_byte, [31:8] report_line,
                                  // [55:32] comment_count
  input  logic        out_tlast,  // last_of_comment
  output int          fail_count,
  output int          pending_words
);

  localparam logic [cce_pkg::REPORT_BITS-1:0] LINE_ONE =
    {{(cce_pkg::REPORT_BITS-1){1'b0}}, 1'b1};

  // Scanner copy
  cce_pkg::mode_t                  scan_mode;
  logic [cce_pkg::REPORT_BITS-1:0] line_no;
  logic [cce_pkg::REPORT_BITS-1:0] start_line;
  logic [cce_pkg::REPORT_BITS-1:0] block_lf;
  logic [7:0]                      held_char;
  logic                            held_v;
  logic [cce_pkg::COUNT_BITS-1:0]  comments_seen;

  // Comment words still owed by the block, oldest first
  cce_pkg::result_t expected_words[$];
  cce_pkg::result_t want;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Saturating add at the line counter width
  function automatic logic [cce_pkg::REPORT_BITS-1:0] line_sum(
    input logic [cce_pkg::REPORT_BITS-1:0] a,
    input logic [cce_pkg::REPORT_BITS-1:0] b);
    logic [cce_pkg::REPORT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[cce_pkg::REPORT_BITS] ? '1 : s[cce_pkg::REPORT_BITS-1:0];
  endfunction

  function automatic void clear_scanner();
    scan_mode     = cce_pkg::MODE_CODE;
    line_no       = LINE_ONE;
    start_line    = '0;
    block_lf      = '0;
    held_char     = '0;
    held_v        = 1'b0;
    comments_seen = '0;
  endfunction

  function automatic void push_word(input logic [7:0] c, input logic last,
                                    input logic [cce_pkg::REPORT_BITS-1:0] line,
                                    input logic [cce_pkg::COUNT_BITS-1:0] count);
    cce_pkg::result_t w;
    w.data  = c;
    w.last  = last;
    w.line  = line;
    w.count = count;
    expected_words.push_back(w);
  endfunction

  // Release the held byte and hold the new one, so output runs one byte behind
  function automatic void hold_char(input logic [7:0] c);
    if (held_v) push_word(held_char, 1'b0, '0, '0);
    held_char = c;
    held_v    = 1'b1;
  endfunction

  // Close a comment: the held byte goes out marked last, if there is one
  function automatic void close_comment(input logic [cce_pkg::REPORT_BITS-1:0] line);
    if (held_v) begin
      if (comments_seen != cce_pkg::COUNT_MAX) comments_seen++;
      push_word(held_char, 1'b1, line, comments_seen);
      held_v = 1'b0;
    end
  endfunction

  // Block comments report start line + newlines - 1, never below the start line
  function automatic logic [cce_pkg::REPORT_BITS-1:0] block_line();
    if (block_lf == '0) return start_line;
    return line_sum(start_line, block_lf - LINE_ONE);
  endfunction

  function automatic void block_content(input logic [7:0] c);
    if (c == cce_pkg::CH_LF) begin
      line_no  = line_sum(line_no, LINE_ONE);
      block_lf = line_sum(block_lf, LINE_ONE);
    end
    if (c != cce_pkg::CH_CR) hold_char(c);
  endfunction

  function automatic void scan_byte(input logic [7:0] c, input logic eot);
    case (scan_mode)
      cce_pkg::MODE_SLASH: begin
        if (c == cce_pkg::CH_SLASH) begin
          scan_mode  = cce_pkg::MODE_LINE;
          start_line = line_no;
        end else if (c == cce_pkg::CH_STAR) begin
          scan_mode  = cce_pkg::MODE_BLOCK;
          start_line = line_no;
          block_lf   = '0;
        end else begin
          // lone slash: rescan this byte as code
          scan_mode = (c == cce_pkg::CH_QUOTE) ? cce_pkg::MODE_STRING : cce_pkg::MODE_CODE;
          if (c == cce_pkg::CH_LF) line_no = line_sum(line_no, LINE_ONE);
        end
      end
      cce_pkg::MODE_LINE: begin
        if (c == cce_pkg::CH_LF) begin
          close_comment(start_line);
          line_no   = line_sum(line_no, LINE_ONE);
          scan_mode = cce_pkg::MODE_CODE;
        end else if (c != cce_pkg::CH_CR) begin
          hold_char(c);
        end
      end
      cce_pkg::MODE_BLOCK: begin
        if (c == cce_pkg::CH_STAR) scan_mode = cce_pkg::MODE_STAR;
        else block_content(c);
      end
      cce_pkg::MODE_STAR: begin
        if (c == cce_pkg::CH_SLASH) begin
          close_comment(block_line());
          scan_mode = cce_pkg::MODE_CODE;
        end else if (c == cce_pkg::CH_STAR) begin
          hold_char(cce_pkg::CH_STAR);
        end else begin
          // star not followed by slash is content
          hold_char(cce_pkg::CH_STAR);
          block_content(c);
          scan_mode = cce_pkg::MODE_BLOCK;
        end
      end
      cce_pkg::MODE_STRING: begin
        if (c == cce_pkg::CH_BACKSLASH) scan_mode = cce_pkg::MODE_ESCAPE;
        else if (c == cce_pkg::CH_QUOTE) scan_mode = cce_pkg::MODE_CODE;
        else if (c == cce_pkg::CH_LF) line_no = line_sum(line_no, LINE_ONE);
      end
      cce_pkg::MODE_ESCAPE: begin
        if (c == cce_pkg::CH_LF) line_no = line_sum(line_no, LINE_ONE);
        scan_mode = cce_pkg::MODE_STRING;
      end
      default: begin
        if (c == cce_pkg::CH_SLASH) scan_mode = cce_pkg::MODE_SLASH;
        else if (c == cce_pkg::CH_QUOTE) scan_mode = cce_pkg::MODE_STRING;
        else begin
          scan_mode = cce_pkg::MODE_CODE;
          if (c == cce_pkg::CH_LF) line_no = line_sum(line_no, LINE_ONE);
        end
      end
    endcase

    // End of text: flush an open comment, then start a fresh text
    if (eot) begin
      if (scan_mode == cce_pkg::MODE_LINE) begin
        close_comment(start_line);
      end else if (scan_mode == cce_pkg::MODE_BLOCK || scan_mode == cce_pkg::MODE_STAR) begin
        if (scan_mode == cce_pkg::MODE_STAR) hold_char(cce_pkg::CH_STAR);
        close_comment(block_line());
      end
      clear_scanner();
    end
  endfunction

  // Compare words leaving the block first, then predict from the word entering
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scanner();
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h last %b", out_tdata, out_tlast));
        end else begin
          want = expected_words.pop_front();
          if (out_tdata[7:0] != want.data)
            report_mismatch($sformatf("comment_byte got %h want %h",
                                      out_tdata[7:0], want.data));
          if (out_tlast != want.last)
            report_mismatch($sformatf("last_of_comment got %b want %b", out_tlast, want.last));
          if (out_tdata[31:8] != want.line)
            report_mismatch($sformatf("report_line got %0d want %0d",
                                      out_tdata[31:8], want.line));
          if (out_tdata[55:32] != want.count)
            report_mismatch($sformatf("comment_count got %0d want %0d",
                                      out_tdata[55:32], want.count));
        end
      end
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
    end
    pending_words = expected_words.size();
  end

endmodule

FILE: dv/tb_c_comment_extractor.sv
`timescale 1ns / 100ps
module tb_c_comment_extractor;

  localparam int RANDOM_BYTES = 320;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tlast;

  int fail_count;
  int pending_words;
  int bytes_sent = 0;
  int cycles     = 0;
  bit in_burst   = 1'b0;
  bit out_burst  = 1'b0;

  logic [7:0] text_chunk[$];
  logic       chunk_eot;
  bit         paused = 1'b0;

  c_comment_extractor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  c_comment_extractor_checker comment_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Pick a source character, biased toward the ones the scanner reacts to
  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6: return 8'h61 + 8'($urandom_range(0, 25));
      7:  return 8'h20;
      8:  return cce_pkg::CH_LF;
      9:  return cce_pkg::CH_CR;
      10: return cce_pkg::CH_STAR;
      11: return cce_pkg::CH_SLASH;
      12: return cce_pkg::CH_QUOTE;
      13: return cce_pkg::CH_BACKSLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Send one word after a random gap; valid stays high when the gap is zero
  task automatic send_byte(input logic [7:0] c, input logic eot);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eot;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
  endtask

  // Hold input until every predicted word has drained
  task automatic drain_output();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Receiver: random stall before each word, with bursts of no stall
  initial begin
    int stall;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(negedge clk);
      while (!out_tvalid) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin
    logic [7:0] directed[$];
    int n;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Line comment with extreme and carriage-return bytes, block comment over
    // two lines with stray stars, lone slash into a string with an escaped
    // quote and a newline, empty block comment, and text ending on a pending
    // star inside an open block comment
    directed = '{cce_pkg::CH_SLASH, cce_pkg::CH_SLASH, 8'hFF, cce_pkg::CH_CR, 8'h00,
                 cce_pkg::CH_LF,
                 cce_pkg::CH_SLASH, cce_pkg::CH_STAR, cce_pkg::CH_LF, cce_pkg::CH_STAR,
                 8'h78, cce_pkg::CH_STAR, cce_pkg::CH_STAR, cce_pkg::CH_SLASH,
                 cce_pkg::CH_SLASH, cce_pkg::CH_QUOTE, cce_pkg::CH_BACKSLASH,
                 cce_pkg::CH_QUOTE, cce_pkg::CH_LF, cce_pkg::CH_QUOTE,
                 cce_pkg::CH_SLASH, cce_pkg::CH_STAR, cce_pkg::CH_STAR, cce_pkg::CH_SLASH,
                 cce_pkg::CH_SLASH, cce_pkg::CH_STAR, 8'h71, cce_pkg::CH_STAR};
    foreach (directed[i]) send_byte(directed[i], i == directed.size() - 1);
    drain_output();

    // Random text built from mostly well-formed tokens
    while (bytes_sent < RANDOM_BYTES + directed.size()) begin
      text_chunk.delete();
      chunk_eot = ($urandom_range(0, 11) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 6);
          repeat (n) text_chunk.push_back(text_char());
        end
        2, 3: begin
          text_chunk.push_back(cce_pkg::CH_SLASH);
          text_chunk.push_back(cce_pkg::CH_SLASH);
          n = $urandom_range(0, 6);
          repeat (n) text_chunk.push_back(text_char());
          text_chunk.push_back(cce_pkg::CH_LF);
        end
        4, 5: begin
          text_chunk.push_back(cce_pkg::CH_SLASH);
          text_chunk.push_back(cce_pkg::CH_STAR);
          n = $urandom_range(0, 8);
          repeat (n) text_chunk.push_back(text_char());
          text_chunk.push_back(cce_pkg::CH_STAR);
          text_chunk.push_back(cce_pkg::CH_SLASH);
        end
        6: begin
          text_chunk.push_back(cce_pkg::CH_QUOTE);
          n = $urandom_range(0, 6);
          repeat (n) text_chunk.push_back(text_char());
          text_chunk.push_back(cce_pkg::CH_QUOTE);
        end
        7: begin
          text_chunk.push_back(cce_pkg::CH_SLASH);
          text_chunk.push_back(text_char());
        end
        8: begin
          n = $urandom_range(1, 4);
          repeat (n) text_chunk.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          // comment left open until the end of the text
          text_chunk.push_back(cce_pkg::CH_SLASH);
          text_chunk.push_back($urandom_range(0, 1) ? cce_pkg::CH_STAR : cce_pkg::CH_SLASH);
          n = $urandom_range(0, 5);
          repeat (n) text_chunk.push_back(text_char());
          chunk_eot = 1'b1;
        end
      endcase
      foreach (text_chunk[i])
        send_byte(text_chunk[i], chunk_eot && (i == text_chunk.size() - 1));
      if (!paused && bytes_sent > RANDOM_BYTES / 2) begin
        paused = 1'b1;
        drain_output();
      end
    end
    send_byte(cce_pkg::CH_LF, 1'b1);

    // Drain, then leave room for any stray word
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0 && pending_words == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
